// ===== rtl/core/median_weighted_sample_filter_defines.svh =====
// Assertion helpers shared by the filter modules.
`ifndef MEDIAN_WEIGHTED_SAMPLE_FILTER_DEFINES_SVH
`define MEDIAN_WEIGHTED_SAMPLE_FILTER_DEFINES_SVH

// Condition holds at every edge outside reset.
`define MWSF_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequence holds in the same cycle as the trigger.
`define MWSF_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequence holds in the cycle after the trigger.
`define MWSF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/mwsf_pkg.sv =====
package mwsf_pkg;

   localparam int SAMPLE_BITS    = 12;
   localparam int CSR_BITS       = 12;
   localparam int CSR_INDEX_BITS = 2;
   localparam int WIDE_BITS      = (SAMPLE_BITS > CSR_BITS) ? SAMPLE_BITS : CSR_BITS;

   localparam int MED_DEPTH      = 3;
   localparam int MED_COUNT_BITS = $clog2(MED_DEPTH);
   localparam int AVG_DEPTH      = 4;
   localparam int AVG_COUNT_BITS = $clog2(AVG_DEPTH);

   // oldest first
   localparam int AVG_WEIGHTS [AVG_DEPTH] = '{1, 2, 3, 4};
   localparam int WEIGHT_TOTAL = AVG_WEIGHTS[0] + AVG_WEIGHTS[1] + AVG_WEIGHTS[2]
                                 + AVG_WEIGHTS[3];

   localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WEIGHT_TOTAL);
   // floor(x / total) = (x * DIV_MULT) >> DIV_SHIFT for every x below 2**SUM_BITS
   localparam int DIV_SHIFT = SUM_BITS + 3;
   localparam int DIV_MULT  = (2 ** DIV_SHIFT + WEIGHT_TOTAL - 1) / WEIGHT_TOTAL;
   localparam int PROD_BITS = 2 * SUM_BITS;

   typedef logic [SAMPLE_BITS-1:0]    sample_type;
   typedef logic [CSR_BITS-1:0]       csr_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [WIDE_BITS-1:0]      wide_type;
   typedef logic [SUM_BITS-1:0]       sum_type;
   typedef logic [PROD_BITS-1:0]      prod_type;
   typedef logic [MED_COUNT_BITS-1:0] med_count_type;
   typedef logic [AVG_COUNT_BITS-1:0] avg_count_type;

   localparam csr_index_type CSR_CLAMP_LOW  = csr_index_type'(0);
   localparam csr_index_type CSR_CLAMP_HIGH = csr_index_type'(1);

   localparam csr_type CLAMP_LOW_RESET  = '0;
   localparam csr_type CLAMP_HIGH_RESET = '1;

   localparam med_count_type MED_LAST = med_count_type'(MED_DEPTH - 1);
   localparam avg_count_type AVG_LAST = avg_count_type'(AVG_DEPTH - 1);

   typedef struct packed {
      csr_type clamp_low;
      csr_type clamp_high;
   } clamp_cfg_type;

   // taps[0] is the newest entry
   typedef struct packed {
      logic                                  full;
      logic [AVG_DEPTH-1:0][SAMPLE_BITS-1:0] taps;
   } avg_snap_type;

endpackage

// ===== rtl/core/mwsf_window.sv =====
`include "median_weighted_sample_filter_defines.svh"

module mwsf_window (
   input  logic                       clock,
   input  logic                       reset,
   input  mwsf_pkg::clamp_cfg_type    cfg,
   input  logic                       smp_valid,
   input  mwsf_pkg::sample_type       smp_sample,
   input  logic                       smp_restart,
   output logic                       smp_ready,
   output logic                       snap_valid,
   output mwsf_pkg::avg_snap_type     snap,
   input  logic                       snap_ready
);

   logic [mwsf_pkg::MED_DEPTH-1:0][mwsf_pkg::SAMPLE_BITS-1:0] median_line_ff, median_line_in;
   logic [mwsf_pkg::AVG_DEPTH-1:0][mwsf_pkg::SAMPLE_BITS-1:0] average_line_ff, average_line_in;
   mwsf_pkg::med_count_type median_count_ff, median_count_in;
   mwsf_pkg::avg_count_type average_count_ff, average_count_in;
   logic                    median_full_ff, median_full_in;
   logic                    average_full_ff, average_full_in;
   logic                    snap_valid_ff, snap_valid_in;
   mwsf_pkg::avg_snap_type  snap_ff, snap_in;

   logic                 advance;
   logic                 take;
   mwsf_pkg::sample_type clamped;
   mwsf_pkg::sample_type med_lo;
   mwsf_pkg::sample_type med_hi;
   mwsf_pkg::sample_type med_mid;
   mwsf_pkg::sample_type med_value;

   assign advance   = !snap_valid_ff || snap_ready;
   assign take      = smp_valid && advance;
   assign smp_ready = advance;

   // low bound wins over high bound
   always_comb begin
      if (mwsf_pkg::wide_type'(smp_sample) < mwsf_pkg::wide_type'(cfg.clamp_low)) begin
         clamped = mwsf_pkg::sample_type'(cfg.clamp_low);
      end else if (mwsf_pkg::wide_type'(smp_sample) > mwsf_pkg::wide_type'(cfg.clamp_high)) begin
         clamped = mwsf_pkg::sample_type'(cfg.clamp_high);
      end else begin
         clamped = smp_sample;
      end
   end

   always_comb begin
      median_line_in   = median_line_ff;
      median_count_in  = median_count_ff;
      median_full_in   = median_full_ff;
      average_line_in  = average_line_ff;
      average_count_in = average_count_ff;
      average_full_in  = average_full_ff;
      med_lo           = '0;
      med_hi           = '0;
      med_mid          = '0;
      med_value        = clamped;
      if (take) begin
         if (smp_restart) begin
            median_line_in   = {mwsf_pkg::MED_DEPTH{smp_sample}};
            average_line_in  = {mwsf_pkg::AVG_DEPTH{smp_sample}};
            median_count_in  = '0;
            average_count_in = '0;
            median_full_in   = 1'b1;
            average_full_in  = 1'b1;
         end else begin
            median_line_in = {median_line_ff[mwsf_pkg::MED_DEPTH-2:0], clamped};
            if (median_count_ff == mwsf_pkg::MED_LAST) begin
               median_count_in = '0;
               median_full_in  = 1'b1;
            end else begin
               median_count_in = median_count_ff + 1'b1;
            end
            med_lo  = (median_line_in[0] < median_line_in[1]) ? median_line_in[0]
                                                                : median_line_in[1];
            med_hi  = (median_line_in[0] < median_line_in[1]) ? median_line_in[1]
                                                                : median_line_in[0];
            med_mid = (med_hi < median_line_in[2]) ? med_hi : median_line_in[2];
            if (median_full_in) begin
               med_value = (med_lo > med_mid) ? med_lo : med_mid;
            end
            average_line_in = {average_line_ff[mwsf_pkg::AVG_DEPTH-2:0], med_value};
            if (average_count_ff == mwsf_pkg::AVG_LAST) begin
               average_count_in = '0;
               average_full_in  = 1'b1;
            end else begin
               average_count_in = average_count_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      snap_valid_in = advance ? smp_valid : snap_valid_ff;
      snap_in.taps  = average_line_in;
      snap_in.full  = average_full_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         median_count_ff  <= '0;
         average_count_ff <= '0;
         median_full_ff   <= 1'b0;
         average_full_ff  <= 1'b0;
         snap_valid_ff    <= 1'b0;
      end else begin
         median_count_ff  <= median_count_in;
         average_count_ff <= average_count_in;
         median_full_ff   <= median_full_in;
         average_full_ff  <= average_full_in;
         snap_valid_ff    <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      median_line_ff  <= median_line_in;
      average_line_ff <= average_line_in;
      if (take) begin
         snap_ff <= snap_in;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

   `MWSF_ASSERT_ALWAYS(a_median_count_range, median_count_ff <= mwsf_pkg::MED_LAST, "median count out of range")
   `MWSF_ASSERT_SAME(a_full_order, average_full_ff, median_full_ff, "average window full before median window")
   `MWSF_ASSERT_NEXT(a_restart_fill, take && smp_restart, median_full_ff && average_full_ff && median_count_ff == '0 && average_count_ff == '0, "restart did not fill both windows")

endmodule

// ===== rtl/core/mwsf_average.sv =====
`include "median_weighted_sample_filter_defines.svh"

module mwsf_average (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    snap_valid,
   input  mwsf_pkg::avg_snap_type  snap,
   output logic                    snap_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output mwsf_pkg::sample_type    rsp_conditioned
);

   logic                 sum_valid_ff, sum_valid_in;
   mwsf_pkg::sum_type    sum_ff, sum_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   mwsf_pkg::sample_type rsp_conditioned_ff, rsp_conditioned_in;

   logic               rsp_en;
   logic               sum_en;
   mwsf_pkg::prod_type prod;

   assign rsp_en     = !rsp_valid_ff || rsp_ready;
   assign sum_en     = !sum_valid_ff || rsp_en;
   assign snap_ready = sum_en;

   // window not yet full: newest entry carries the whole weight, so it passes unchanged
   always_comb begin
      sum_in = '0;
      if (snap.full) begin
         for (int k = 0; k < mwsf_pkg::AVG_DEPTH; k++) begin
            sum_in = sum_in + mwsf_pkg::sum_type'(snap.taps[k])
                     * mwsf_pkg::sum_type'(mwsf_pkg::AVG_WEIGHTS[mwsf_pkg::AVG_DEPTH-1-k]);
         end
      end else begin
         sum_in = mwsf_pkg::sum_type'(snap.taps[0])
                  * mwsf_pkg::sum_type'(mwsf_pkg::WEIGHT_TOTAL);
      end
      sum_valid_in = sum_en ? snap_valid : sum_valid_ff;
   end

   always_comb begin
      prod               = mwsf_pkg::prod_type'(sum_ff)
                           * mwsf_pkg::prod_type'(mwsf_pkg::DIV_MULT);
      rsp_conditioned_in = prod[mwsf_pkg::DIV_SHIFT +: mwsf_pkg::SAMPLE_BITS];
      rsp_valid_in       = rsp_en ? sum_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= sum_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_en) begin
         sum_ff <= sum_in;
      end
      if (rsp_en) begin
         rsp_conditioned_ff <= rsp_conditioned_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_conditioned = rsp_conditioned_ff;

   `MWSF_ASSERT_NEXT(a_sum_hold, sum_valid_ff && !sum_en, sum_valid_ff && $stable(sum_ff), "stalled sum stage changed")
   `MWSF_ASSERT_NEXT(a_quotient, rsp_en && sum_valid_ff, (mwsf_pkg::prod_type'(rsp_conditioned_ff) * mwsf_pkg::prod_type'(mwsf_pkg::WEIGHT_TOTAL) <= mwsf_pkg::prod_type'($past(sum_ff))) && (mwsf_pkg::prod_type'($past(sum_ff)) < mwsf_pkg::prod_type'(rsp_conditioned_ff) * mwsf_pkg::prod_type'(mwsf_pkg::WEIGHT_TOTAL) + mwsf_pkg::prod_type'(mwsf_pkg::WEIGHT_TOTAL)), "weighted mean quotient wrong")

endmodule

// ===== rtl/core/median_weighted_sample_filter.sv =====
// Sample conditioning filter: clamp, median of three, weighted mean of four.
// Request channel (req_valid/req_ready): one converter sample per transaction,
// with req_restart preloading both windows with that raw sample.
// Response channel (rsp_valid/rsp_ready): one conditioned value per request,
// in request order.
// Register channel (csr_valid/csr_ready): csr_index 0 writes clamp_low,
// 1 writes clamp_high, other indices are ignored; always ready. Write only
// while no request is in flight.
// A result passes through the input register, window update, weighted sum and
// divide-by-ten result register, and any of them can hold it under back-pressure.
// Throughput: one transaction per cycle while rsp_ready stays high; the window
// update is the only stateful step.
// Reset: windows empty, clamp_low 0, clamp_high 4095, all stages empty.
// Receiver stall: the result register holds; the four stages keep filling
// and req_ready falls only once all four hold a transaction.
module median_weighted_sample_filter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mwsf_pkg::sample_type          req_sample,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mwsf_pkg::sample_type          rsp_conditioned,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  mwsf_pkg::csr_index_type       csr_index,
   input  mwsf_pkg::csr_type             csr_wdata
);

   logic                    smp_valid_ff, smp_valid_in;
   mwsf_pkg::sample_type    smp_sample_ff;
   logic                    smp_restart_ff;
   mwsf_pkg::clamp_cfg_type cfg_ff, cfg_in;

   logic                   win_ready;
   logic                   snap_valid;
   mwsf_pkg::avg_snap_type snap;
   logic                   snap_ready;

   assign req_ready = !smp_valid_ff || win_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      smp_valid_in = req_ready ? req_valid : smp_valid_ff;
      cfg_in       = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            mwsf_pkg::CSR_CLAMP_LOW:  cfg_in.clamp_low  = csr_wdata;
            mwsf_pkg::CSR_CLAMP_HIGH: cfg_in.clamp_high = csr_wdata;
            default:                  cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff      <= 1'b0;
         cfg_ff.clamp_low  <= mwsf_pkg::CLAMP_LOW_RESET;
         cfg_ff.clamp_high <= mwsf_pkg::CLAMP_HIGH_RESET;
      end else begin
         smp_valid_ff <= smp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         smp_sample_ff  <= req_sample;
         smp_restart_ff <= req_restart;
      end
   end

   mwsf_window u_window (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .smp_valid   (smp_valid_ff),
      .smp_sample  (smp_sample_ff),
      .smp_restart (smp_restart_ff),
      .smp_ready   (win_ready),
      .snap_valid  (snap_valid),
      .snap        (snap),
      .snap_ready  (snap_ready)
   );

   mwsf_average u_average (
      .clock           (clock),
      .reset           (reset),
      .snap_valid      (snap_valid),
      .snap            (snap),
      .snap_ready      (snap_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_conditioned (rsp_conditioned)
   );

endmodule

// ===== tb/median_weighted_sample_filter_test.sv =====
module median_weighted_sample_filter_test;

   localparam int PHASES         = 9;
   localparam int PHASE_ITEMS    = 150;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int MAX_REPORTS    = 10;

   // indices with no register behind them
   localparam mwsf_pkg::csr_index_type CSR_SPARE_A = mwsf_pkg::csr_index_type'(2);
   localparam mwsf_pkg::csr_index_type CSR_SPARE_B = mwsf_pkg::csr_index_type'(3);

   class filter_scoreboard;
      mwsf_pkg::csr_type    clamp_lo;
      mwsf_pkg::csr_type    clamp_hi;
      mwsf_pkg::sample_type med_win [mwsf_pkg::MED_DEPTH];
      int                   med_pos;
      bit                   med_full;
      mwsf_pkg::sample_type avg_win [mwsf_pkg::AVG_DEPTH];
      int                   avg_pos;
      bit                   avg_full;
      mwsf_pkg::sample_type expected_q [$];
      int                   errors;
      int                   checked;
      int                   accepted;
      int                   restarts;
      int                   reg_writes;

      function new();
         clamp_lo = mwsf_pkg::CLAMP_LOW_RESET;
         clamp_hi = mwsf_pkg::CLAMP_HIGH_RESET;
         foreach (med_win[i]) med_win[i] = '0;
         foreach (avg_win[i]) avg_win[i] = '0;
         med_pos    = 0;
         avg_pos    = 0;
         med_full   = 1'b0;
         avg_full   = 1'b0;
         errors     = 0;
         checked    = 0;
         accepted   = 0;
         restarts   = 0;
         reg_writes = 0;
      endfunction

      function void write_reg(mwsf_pkg::csr_index_type idx, mwsf_pkg::csr_type data);
         reg_writes++;
         if (idx == mwsf_pkg::CSR_CLAMP_LOW) begin
            clamp_lo = data;
         end else if (idx == mwsf_pkg::CSR_CLAMP_HIGH) begin
            clamp_hi = data;
         end
      endfunction

      function void note_request(mwsf_pkg::sample_type raw, logic restart);
         mwsf_pkg::sample_type v;
         mwsf_pkg::sample_type a;
         mwsf_pkg::sample_type b;
         mwsf_pkg::sample_type c;
         int                   total;
         int                   newest;
         accepted++;
         if (restart) begin
            restarts++;
            foreach (med_win[i]) med_win[i] = raw;
            foreach (avg_win[i]) avg_win[i] = raw;
            med_pos  = 0;
            avg_pos  = 0;
            med_full = 1'b1;
            avg_full = 1'b1;
            expected_q.push_back(raw);
            return;
         end
         // low bound wins when the bounds cross
         if (raw < clamp_lo) v = clamp_lo;
         else if (raw > clamp_hi) v = clamp_hi;
         else v = raw;
         med_win[med_pos] = v;
         med_pos = (med_pos + 1) % mwsf_pkg::MED_DEPTH;
         if (med_pos == 0) med_full = 1'b1;
         if (med_full) begin
            a = med_win[0];
            b = med_win[1];
            c = med_win[2];
            if (a > b) v = (b > c) ? b : ((a > c) ? c : a);
            else v = (a > c) ? a : ((b > c) ? c : b);
         end
         avg_win[avg_pos] = v;
         avg_pos = (avg_pos + 1) % mwsf_pkg::AVG_DEPTH;
         if (avg_pos == 0) avg_full = 1'b1;
         if (avg_full) begin
            total  = 0;
            newest = (avg_pos + mwsf_pkg::AVG_DEPTH - 1) % mwsf_pkg::AVG_DEPTH;
            for (int age = 0; age < mwsf_pkg::AVG_DEPTH; age++) begin
               total += int'(avg_win[(newest + mwsf_pkg::AVG_DEPTH - age) % mwsf_pkg::AVG_DEPTH])
                        * mwsf_pkg::AVG_WEIGHTS[mwsf_pkg::AVG_DEPTH - 1 - age];
            end
            v = mwsf_pkg::sample_type'(total / mwsf_pkg::WEIGHT_TOTAL);
         end
         expected_q.push_back(v);
      endfunction

      function void check_response(mwsf_pkg::sample_type got);
         mwsf_pkg::sample_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) $display("unexpected result: got %0d", got);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("result %0d mismatch: expected %0d, got %0d", checked, want, got);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                    clock           = 1'b0;
   logic                    reset           = 1'b1;
   logic                    req_valid       = 1'b0;
   logic                    req_ready;
   mwsf_pkg::sample_type    req_sample      = '0;
   logic                    req_restart     = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready       = 1'b0;
   mwsf_pkg::sample_type    rsp_conditioned;
   logic                    csr_valid       = 1'b0;
   logic                    csr_ready;
   mwsf_pkg::csr_index_type csr_index       = mwsf_pkg::CSR_CLAMP_LOW;
   mwsf_pkg::csr_type       csr_wdata       = '0;

   int send_idle_pct = 18;
   int recv_idle_pct = 51;
   int idle_cycles   = 0;
   int settings_used = 0;

   filter_scoreboard sb = new();

   median_weighted_sample_filter dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_conditioned (rsp_conditioned),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_sample, req_restart);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_conditioned);
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_wdata);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic send_item(mwsf_pkg::sample_type s, logic r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_sample  <= s;
      req_restart <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // hold off until every result has drained and the pipeline is empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(mwsf_pkg::csr_index_type idx, mwsf_pkg::csr_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_clamp(mwsf_pkg::csr_type lo, mwsf_pkg::csr_type hi);
      write_csr(mwsf_pkg::CSR_CLAMP_LOW, lo);
      write_csr(mwsf_pkg::CSR_CLAMP_HIGH, hi);
      // unused index last, so aliasing onto a real register shows up
      write_csr($urandom_range(1) ? CSR_SPARE_A : CSR_SPARE_B,
                mwsf_pkg::csr_type'($urandom));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   initial begin
      mwsf_pkg::csr_type    lo;
      mwsf_pkg::csr_type    hi;
      mwsf_pkg::csr_type    ra;
      mwsf_pkg::csr_type    rb;
      mwsf_pkg::sample_type s;
      mwsf_pkg::sample_type prev;
      logic                 r;
      int                   pause_at;

      prev = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset bounds: windows filling, extremes, bit patterns, restarts
      send_item(12'h000, 1'b0);
      send_item(12'hFFF, 1'b0);
      send_item(12'hAAA, 1'b0);
      send_item(12'h555, 1'b0);
      send_item(12'hFFF, 1'b0);
      send_item(12'h000, 1'b0);
      send_item(12'hFFF, 1'b1);
      send_item(12'h000, 1'b0);
      send_item(12'h000, 1'b0);
      send_item(12'h000, 1'b1);
      send_item(12'hFFF, 1'b0);
      send_item(12'h001, 1'b0);

      settle();
      program_clamp(12'd100, 12'd4000);
      send_item(12'd50, 1'b0);
      send_item(12'd4050, 1'b0);
      send_item(12'd100, 1'b0);
      send_item(12'd4000, 1'b0);
      send_item(12'd99, 1'b0);
      send_item(12'd4001, 1'b0);
      send_item(12'd50, 1'b1);
      send_item(12'hFFF, 1'b0);
      send_item(12'h000, 1'b0);

      // crossed bounds
      settle();
      program_clamp(12'd3000, 12'd1000);
      send_item(12'd2000, 1'b0);
      send_item(12'd500, 1'b0);
      send_item(12'd3500, 1'b0);

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 3) begin
            send_idle_pct = 51;
            recv_idle_pct = 18;
         end else if (phase == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         ra = mwsf_pkg::csr_type'($urandom_range(4095));
         rb = mwsf_pkg::csr_type'($urandom_range(4095));
         case (phase)
            0: begin lo = '0; hi = '1; end
            1: begin lo = '1; hi = '0; end
            3: begin lo = '0; hi = '0; end
            4: begin lo = '1; hi = '1; end
            6: begin lo = ra; hi = rb; end
            7: begin lo = 12'd1; hi = 12'd4094; end
            default: begin
               lo = (ra < rb) ? ra : rb;
               hi = (ra < rb) ? rb : ra;
            end
         endcase
         settle();
         program_clamp(lo, hi);
         pause_at = $urandom_range(20, PHASE_ITEMS - 20);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == pause_at) settle();
            case ($urandom_range(11))
               0: s = '0;
               1: s = '1;
               2: s = mwsf_pkg::sample_type'(lo + $urandom_range(4) - 2);
               3: s = mwsf_pkg::sample_type'(hi + $urandom_range(4) - 2);
               4, 5: s = mwsf_pkg::sample_type'(prev + $urandom_range(64) - 32);
               default: s = mwsf_pkg::sample_type'($urandom_range(4095));
            endcase
            r = ($urandom_range(15) == 0);
            prev = s;
            send_item(s, r);
         end
      end

      settle();
      if (sb.pending() != 0) sb.errors += sb.pending();
      $display("Covered %0d samples (%0d restarts), %0d clamp settings, %0d register writes.",
               sb.accepted, sb.restarts, settings_used, sb.reg_writes);
      $display("Checked %0d results, %0d errors.", sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
